### rtl/stdp_pkg.sv
// ----------------------------------------------------------------------------
// stdp_pkg
// Shared constants, codes, state type and exp table entry function for the STDP synapse.
// ----------------------------------------------------------------------------
package stdp_pkg;

   localparam int HISTORY_DEPTH_DEF   = 64;
   localparam int EXP_TABLE_DEPTH_DEF = 256;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_PRE   = 2'd2;
   localparam logic [1:0] CMD_POST  = 2'd3;

   localparam logic [2:0] REG_PROTO_MODE   = 3'd0;
   localparam logic [2:0] REG_WEIGHT       = 3'd1;
   localparam logic [2:0] REG_INIT_STRENGTH = 3'd2;
   localparam logic [2:0] REG_PRE_WINDOW   = 3'd3;
   localparam logic [2:0] REG_POST_WINDOW  = 3'd4;
   localparam logic [2:0] REG_PRE_RATE     = 3'd5;
   localparam logic [2:0] REG_POST_RATE    = 3'd6;
   localparam logic [2:0] REG_HISTORY_LEN  = 3'd7;

   localparam int CSR_IDX_W = 4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RING_RD,
      ST_RD_WAIT,
      ST_MUL1,
      ST_DIV,
      ST_MUL2,
      ST_WR,
      ST_PDIV,
      ST_EXP,
      ST_PMUL,
      ST_PADD,
      ST_MOD,
      ST_DONE
   } state_type;

   // exp(-i/depth) in Q16.16, Taylor series in Q2.30 as integers
   function automatic logic [31:0] exp_entry(input int unsigned i, input int unsigned depth);
      logic [63:0] x;
      logic [63:0] term;
      logic signed [63:0] sum;
      x    = (64'(i) << 30) / 64'(depth);
      term = 64'd1 << 30;
      sum  = 64'sd1 << 30;
      for (int k = 1; k <= 24; k++) begin
         term = ((term * x) >> 30) / 64'(k);
         if (k % 2 == 1) sum = sum - $signed(term);
         else sum = sum + $signed(term);
      end
      if (sum < 0) sum = 0;
      return 32'((64'(sum) + 64'd8192) >> 14);
   endfunction

endpackage

### rtl/stdp_if.sv
// ----------------------------------------------------------------------------
// stdp_req_if / stdp_rsp_if / stdp_csr_if
// Valid/ready channels of the synapse.
// ----------------------------------------------------------------------------
interface stdp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [31:0] tick_time;
   logic signed [31:0] signal_in;
   logic [5:0]  read_delay;
   modport source (output valid, cmd, tick_time, signal_in, read_delay, input ready);
   modport sink   (input valid, cmd, tick_time, signal_in, read_delay, output ready);
endinterface

interface stdp_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] signal_out;
   logic signed [31:0] strength_now;
   logic [15:0] maturity_now;
   logic        activity;
   modport source (output valid, signal_out, strength_now, maturity_now, activity,
                   input ready);
   modport sink   (input valid, signal_out, strength_now, maturity_now, activity,
                   output ready);
endinterface

interface stdp_csr_if;
   logic        valid;
   logic        ready;
   logic [stdp_pkg::CSR_IDX_W-1:0] index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/stdp_serdiv.sv
// ----------------------------------------------------------------------------
// stdp_serdiv
// Restoring divider, one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
module stdp_serdiv #(
   parameter int W = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         busy,
   output logic [W-1:0] quotient,
   output logic [W-1:0] remainder
);
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  dsr_ff, dsr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W:0]    trial;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      trial  = {rem_ff, quo_ff[W-1]} - {1'b0, dsr_ff};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = CW'(W);
      end else if (cnt_ff != '0) begin
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[W-2:0], quo_ff[W-1]};
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy      = (cnt_ff != '0);
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

### rtl/stdp_serial_mul.sv
// ----------------------------------------------------------------------------
// stdp_serial_mul
// Shift-and-add multiplier, one multiplier bit per cycle, unsigned.
// ----------------------------------------------------------------------------
module stdp_serial_mul #(
   parameter int W = 32
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [W-1:0]   a,
   input  logic [W-1:0]   b,
   output logic           busy,
   output logic [2*W-1:0] product
);
   localparam int CW = $clog2(W + 1);

   logic [2*W-1:0] acc_ff, acc_in;
   logic [2*W-1:0] mcd_ff, mcd_in;
   logic [W-1:0]   mpr_ff, mpr_in;
   logic [CW-1:0]  cnt_ff, cnt_in;

   always_comb begin
      acc_in = acc_ff;
      mcd_in = mcd_ff;
      mpr_in = mpr_ff;
      cnt_in = cnt_ff;
      if (start) begin
         acc_in = '0;
         mcd_in = {{W{1'b0}}, a};
         mpr_in = b;
         cnt_in = CW'(W);
      end else if (cnt_ff != '0) begin
         if (mpr_ff[0]) acc_in = acc_ff + mcd_ff;
         mcd_in = {mcd_ff[2*W-2:0], 1'b0};
         mpr_in = {1'b0, mpr_ff[W-1:1]};
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      acc_ff <= acc_in;
      mcd_ff <= mcd_in;
      mpr_ff <= mpr_in;
   end

   assign busy    = (cnt_ff != '0);
   assign product = acc_ff;

endmodule

### rtl/stdp_synapse_with_delay_line.sv
// ----------------------------------------------------------------------------
// stdp_synapse_with_delay_line
// Plastic synapse with spike-timing learning and a delayed signal ring.
// ----------------------------------------------------------------------------
// One item at a time: the next transfer is taken only once the result has
// gone, and a waiting result holds the input. Every item first reduces its
// ring index modulo the ring length on the shared 64-bit serial divider. A
// write adds a serial multiply, a second divide and a second multiply. A
// paired spike outside proto mode adds a divide for the table index and a
// multiply. Ring entries are tracked by one valid bit each; reset clears
// them at once.
// ----------------------------------------------------------------------------
module stdp_synapse_with_delay_line #(
   parameter int HISTORY_DEPTH   = stdp_pkg::HISTORY_DEPTH_DEF,
   parameter int EXP_TABLE_DEPTH = stdp_pkg::EXP_TABLE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   stdp_req_if.sink   req,
   stdp_rsp_if.source rsp,
   stdp_csr_if.sink   csr
);
   localparam int HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int EW = (EXP_TABLE_DEPTH > 1) ? $clog2(EXP_TABLE_DEPTH) : 1;

   // configuration
   logic               proto_ff;
   logic signed [31:0] weight_ff, prerate_ff, postrate_ff;
   logic [15:0]        prewin_ff, postwin_ff;
   logic [6:0]         hlen_ff;

   // state
   logic [31:0]        pretime_ff, posttime_ff;
   logic               preseen_ff, postseen_ff;
   logic signed [31:0] strength_ff;
   logic [15:0]        maturity_ff;
   logic [HISTORY_DEPTH-1:0] rvalid_ff;
   logic signed [31:0] ring [HISTORY_DEPTH];
   logic signed [31:0] ring_q;

   // item
   logic [1:0]         cmd_ff;
   logic [31:0]        time_ff;
   logic signed [31:0] sig_ff;
   logic [5:0]         delay_ff;
   logic               neg_ff;
   logic [63:0]        tmp_ff;
   logic [31:0]        rate_mag_ff;
   logic [HW-1:0]      idx_ff;

   // result
   logic               rvld_ff;
   logic signed [31:0] rsig_ff;
   logic               ract_ff;

   stdp_pkg::state_type state_ff, state_in;

   // engines
   logic        div_start, div_busy, mul_start, mul_busy;
   logic [63:0] div_a, div_b, div_q, div_r;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;

   stdp_serdiv #(.W(64)) u_div (
      .clock, .reset, .start(div_start), .dividend(div_a), .divisor(div_b),
      .busy(div_busy), .quotient(div_q), .remainder(div_r));

   stdp_serial_mul #(.W(32)) u_mul (
      .clock, .reset, .start(mul_start), .a(mul_a), .b(mul_b),
      .busy(mul_busy), .product(mul_p));

   logic [31:0] len_eff;
   logic [31:0] aw, as_, asig;
   logic [31:0] dt;
   logic [15:0] win;
   logic        pair;
   logic [31:0] exp_val;
   logic [EW-1:0] eidx;
   logic signed [33:0] nsum;
   logic [63:0] wmag;
   logic signed [31:0] wval;
   logic [31:0] exp_rom [EXP_TABLE_DEPTH];

   for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_exp
      assign exp_rom[g] = stdp_pkg::exp_entry(g, EXP_TABLE_DEPTH);
   end

   always_comb begin
      if (hlen_ff == '0) len_eff = 32'd1;
      else if (32'(hlen_ff) > 32'(HISTORY_DEPTH)) len_eff = 32'(HISTORY_DEPTH);
      else len_eff = 32'(hlen_ff);
      aw   = weight_ff[31] ? 32'(-weight_ff) : 32'(weight_ff);
      as_  = strength_ff[31] ? 32'(-strength_ff) : 32'(strength_ff);
      asig = sig_ff[31] ? 32'(-sig_ff) : 32'(sig_ff);
      if (cmd_ff == stdp_pkg::CMD_PRE) begin
         dt  = time_ff - posttime_ff;
         win = prewin_ff;
      end else begin
         dt  = time_ff - pretime_ff;
         win = postwin_ff;
      end
      pair = (dt < 32'(win));
      eidx = (div_q >= 64'(EXP_TABLE_DEPTH)) ? EW'(EXP_TABLE_DEPTH - 1) : EW'(div_q);
      exp_val = exp_rom[eidx];
      nsum = neg_ff ? (34'(strength_ff) - $signed({2'b0, mul_p[47:16]}))
                    : (34'(strength_ff) + $signed({2'b0, mul_p[47:16]}));
      wmag = mul_p >> 16;
      if (tmp_ff == '0) wval = '0;
      else if (neg_ff) wval = (wmag >= 64'h8000_0000) ? 32'sh8000_0000 : 32'(-wmag);
      else wval = (wmag > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(wmag);
   end

   logic acc_req, acc_csr;
   assign req.ready = (state_ff == stdp_pkg::ST_IDLE) && !rvld_ff;
   assign csr.ready = 1'b1;
   assign acc_req   = req.valid && req.ready;
   assign acc_csr   = csr.valid && csr.ready;

   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      mul_start = 1'b0;
      div_a     = '0;
      div_b     = 64'd1;
      mul_a     = '0;
      mul_b     = '0;
      unique case (state_ff)
         stdp_pkg::ST_IDLE: if (acc_req) state_in = stdp_pkg::ST_MOD;
         stdp_pkg::ST_MOD: begin
            div_start = 1'b1;
            div_a = (cmd_ff == stdp_pkg::CMD_READ) ? 64'(time_ff - 32'(delay_ff) - 32'd1)
                                                   : 64'(time_ff);
            div_b = 64'(len_eff);
            state_in = stdp_pkg::ST_RING_RD;
         end
         stdp_pkg::ST_RING_RD: if (!div_busy) begin
            unique case (cmd_ff)
               stdp_pkg::CMD_WRITE: begin
                  mul_start = 1'b1;
                  mul_a = aw;
                  mul_b = as_;
                  state_in = stdp_pkg::ST_MUL1;
               end
               stdp_pkg::CMD_READ: state_in = stdp_pkg::ST_RD_WAIT;
               default: begin
                  if (!proto_ff && pair &&
                      ((cmd_ff == stdp_pkg::CMD_PRE) ? postseen_ff : preseen_ff)) begin
                     div_start = 1'b1;
                     div_a = 64'(dt) * 64'(EXP_TABLE_DEPTH);
                     div_b = 64'(win);
                     state_in = stdp_pkg::ST_PDIV;
                  end else begin
                     state_in = stdp_pkg::ST_DONE;
                  end
               end
            endcase
         end
         stdp_pkg::ST_RD_WAIT: state_in = stdp_pkg::ST_DONE;
         stdp_pkg::ST_MUL1: if (!mul_busy) begin
            div_start = 1'b1;
            div_a = mul_p;
            div_b = (64'(aw) + 64'(as_) == 64'd0) ? 64'd1 : 64'(aw) + 64'(as_);
            state_in = stdp_pkg::ST_DIV;
         end
         stdp_pkg::ST_DIV: if (!div_busy) begin
            mul_start = 1'b1;
            mul_a = asig;
            mul_b = 32'(div_q);
            state_in = stdp_pkg::ST_MUL2;
         end
         stdp_pkg::ST_MUL2: if (!mul_busy) state_in = stdp_pkg::ST_WR;
         stdp_pkg::ST_WR: state_in = stdp_pkg::ST_DONE;
         stdp_pkg::ST_PDIV: if (!div_busy) state_in = stdp_pkg::ST_EXP;
         stdp_pkg::ST_EXP: begin
            mul_start = 1'b1;
            mul_a = rate_mag_ff;
            mul_b = tmp_ff[31:0];
            state_in = stdp_pkg::ST_PMUL;
         end
         stdp_pkg::ST_PMUL: if (!mul_busy) state_in = stdp_pkg::ST_PADD;
         stdp_pkg::ST_PADD: state_in = stdp_pkg::ST_DONE;
         stdp_pkg::ST_DONE: state_in = stdp_pkg::ST_IDLE;
         default: state_in = stdp_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stdp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == stdp_pkg::ST_WR) ring[idx_ff] <= wval;
      ring_q <= ring[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (acc_req) begin
         cmd_ff   <= req.cmd;
         time_ff  <= req.tick_time;
         sig_ff   <= req.signal_in;
         delay_ff <= req.read_delay;
      end
      if (state_ff == stdp_pkg::ST_RING_RD && !div_busy) begin
         idx_ff <= HW'(div_r);
         if (cmd_ff == stdp_pkg::CMD_PRE) begin
            neg_ff      <= prerate_ff[31];
            rate_mag_ff <= prerate_ff[31] ? 32'(-prerate_ff) : 32'(prerate_ff);
         end else begin
            neg_ff      <= postrate_ff[31];
            rate_mag_ff <= postrate_ff[31] ? 32'(-postrate_ff) : 32'(postrate_ff);
         end
      end
      if (state_ff == stdp_pkg::ST_MUL1 && !mul_busy) begin
         tmp_ff <= 64'(64'(aw) + 64'(as_) != 64'd0);
         neg_ff <= sig_ff[31] ^ weight_ff[31] ^ strength_ff[31];
      end
      if (state_ff == stdp_pkg::ST_PDIV && !div_busy) tmp_ff <= 64'(exp_val);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         proto_ff    <= 1'b0;
         weight_ff   <= 32'sd65536;
         prewin_ff   <= 16'd20;
         postwin_ff  <= 16'd20;
         prerate_ff  <= 32'sd655;
         postrate_ff <= 32'sd655;
         hlen_ff     <= 7'd64;
         pretime_ff  <= '0;
         posttime_ff <= '0;
         preseen_ff  <= 1'b0;
         postseen_ff <= 1'b0;
         strength_ff <= 32'sd65536;
         maturity_ff <= '0;
         rvalid_ff   <= '0;
         rvld_ff     <= 1'b0;
         rsig_ff     <= '0;
         ract_ff     <= 1'b0;
      end else begin
         if (acc_csr) begin
            unique case (csr.index)
               4'(stdp_pkg::REG_PROTO_MODE):    proto_ff    <= csr.data[0];
               4'(stdp_pkg::REG_WEIGHT):        weight_ff   <= csr.data;
               4'(stdp_pkg::REG_INIT_STRENGTH): strength_ff <= csr.data;
               4'(stdp_pkg::REG_PRE_WINDOW):    prewin_ff   <= csr.data[15:0];
               4'(stdp_pkg::REG_POST_WINDOW):   postwin_ff  <= csr.data[15:0];
               4'(stdp_pkg::REG_PRE_RATE):      prerate_ff  <= csr.data;
               4'(stdp_pkg::REG_POST_RATE):     postrate_ff <= csr.data;
               4'(stdp_pkg::REG_HISTORY_LEN):   hlen_ff     <= csr.data[6:0];
               default: ;
            endcase
         end
         if (state_ff == stdp_pkg::ST_WR) rvalid_ff[idx_ff] <= 1'b1;
         if (state_ff == stdp_pkg::ST_PADD) begin
            if (nsum > 34'sh0_7FFF_FFFF) strength_ff <= 32'sh7FFF_FFFF;
            else if (nsum < -34'sh0_8000_0000) strength_ff <= 32'sh8000_0000;
            else strength_ff <= 32'(nsum);
         end
         if (state_ff == stdp_pkg::ST_DONE) begin
            rvld_ff <= 1'b1;
            rsig_ff <= (cmd_ff == stdp_pkg::CMD_READ && rvalid_ff[idx_ff]) ? ring_q : '0;
            ract_ff <= (cmd_ff == stdp_pkg::CMD_PRE) && proto_ff;
            if (cmd_ff == stdp_pkg::CMD_PRE) begin
               pretime_ff <= time_ff;
               preseen_ff <= 1'b1;
            end
            if (cmd_ff == stdp_pkg::CMD_POST) begin
               posttime_ff <= time_ff;
               postseen_ff <= 1'b1;
               if (preseen_ff && proto_ff && pair && maturity_ff != 16'hFFFF)
                  maturity_ff <= maturity_ff + 16'd1;
            end
         end else if (rvld_ff && rsp.ready) begin
            rvld_ff <= 1'b0;
         end
      end
   end

   assign rsp.valid        = rvld_ff;
   assign rsp.signal_out   = rsig_ff;
   assign rsp.strength_now = strength_ff;
   assign rsp.maturity_now = maturity_ff;
   assign rsp.activity     = ract_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != stdp_pkg::ST_IDLE) |-> !req.ready)
      else $error("input taken while busy");
   a_done_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == stdp_pkg::ST_DONE) |=> rsp.valid)
      else $error("no result after item");
   a_act_only_pre: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.activity) |-> (cmd_ff == stdp_pkg::CMD_PRE))
      else $error("activity on non-pre item");

endmodule

### sim/stdp_tb_if.sv
// ----------------------------------------------------------------------------
// stdp_tb_if
// Interfaces used by the testbench come from the RTL; this file holds the
// result record shared by the stimulus and checking side of the bench.
// ----------------------------------------------------------------------------
package stdp_tb_pkg;

   typedef struct packed {
      logic signed [31:0] signal_out;
      logic signed [31:0] strength_now;
      logic [15:0]        maturity_now;
      logic               activity;
   } synapse_result_type;

endpackage

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the plastic synapse: ring writes and delayed reads, spike pairing in
// normal mode and maturity counting in proto mode, under random idling on
// both channels, against an in-bench prediction of every result.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 64;
   localparam int EXP_DEPTH = 256;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic quiet = 1'b0;
   int   failures = 0;

   stdp_req_if req ();
   stdp_rsp_if rsp ();
   stdp_csr_if csr ();

   stdp_synapse_with_delay_line dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   always #10 clock = ~clock;

   // synapse state mirror
   logic signed [31:0] ring_q [DEPTH];
   logic [31:0]        pre_t, post_t;
   logic               pre_ok, post_ok;
   logic signed [31:0] strength_q;
   logic [15:0]        maturity_q;
   logic               proto_q;
   logic signed [31:0] weight_q, init_q, pre_rate_q, post_rate_q;
   logic [15:0]        pre_win_q, post_win_q;
   logic [6:0]         hist_len_q;
   logic [31:0]        exp_lut [EXP_DEPTH];
   stdp_tb_pkg::synapse_result_type expected_results [$];

   function automatic logic [31:0] taylor_exp(int unsigned i);
      logic [63:0] x, term;
      logic signed [63:0] acc;
      x = (64'(i) << 30) / 64'(EXP_DEPTH);
      term = 64'd1 << 30;
      acc = 64'sd1 << 30;
      for (int k = 1; k <= 24; k++) begin
         term = ((term * x) >> 30) / 64'(k);
         if (k % 2 == 1) acc = acc - $signed(term);
         else acc = acc + $signed(term);
      end
      if (acc < 0) acc = 0;
      return 32'((64'(acc) + 64'd8192) >> 14);
   endfunction

   function automatic logic [63:0] magnitude(logic signed [31:0] v);
      return v < 0 ? 64'(-64'sd1 * 64'(v)) : 64'(v);
   endfunction

   function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic int unsigned ring_length();
      if (hist_len_q == 0) return 1;
      if (hist_len_q > DEPTH) return DEPTH;
      return 32'(hist_len_q);
   endfunction

   function automatic void pair_strength(logic [31:0] now, logic [31:0] then_t,
                                         logic [15:0] win, logic signed [31:0] rate);
      logic [31:0] dt;
      logic [63:0] idx, inc;
      dt = now - then_t;
      if (dt >= {16'd0, win}) return;
      idx = (64'(dt) * 64'(EXP_DEPTH)) / 64'(win);
      if (idx >= 64'(EXP_DEPTH)) idx = 64'(EXP_DEPTH - 1);
      inc = (magnitude(rate) * 64'(exp_lut[idx])) >> 16;
      if (rate < 0) strength_q = clamp32(64'(strength_q) - $signed(inc));
      else strength_q = clamp32(64'(strength_q) + $signed(inc));
   endfunction

   function automatic void synapse_reset();
      foreach (ring_q[i]) ring_q[i] = 0;
      proto_q = 0; weight_q = 65536; init_q = 65536;
      pre_win_q = 20; post_win_q = 20; pre_rate_q = 655; post_rate_q = 655;
      hist_len_q = 64;
      pre_t = 0; post_t = 0; pre_ok = 0; post_ok = 0;
      strength_q = 65536; maturity_q = 0;
   endfunction

   function automatic void synapse_config(logic [2:0] idx, logic [31:0] v);
      case (idx)
         stdp_pkg::REG_PROTO_MODE:    proto_q = v[0];
         stdp_pkg::REG_WEIGHT:        weight_q = v;
         stdp_pkg::REG_INIT_STRENGTH: begin
            init_q = v;
            strength_q = v;
         end
         stdp_pkg::REG_PRE_WINDOW:    pre_win_q = v[15:0];
         stdp_pkg::REG_POST_WINDOW:   post_win_q = v[15:0];
         stdp_pkg::REG_PRE_RATE:      pre_rate_q = v;
         stdp_pkg::REG_POST_RATE:     post_rate_q = v;
         stdp_pkg::REG_HISTORY_LEN:   hist_len_q = v[6:0];
         default: ;
      endcase
   endfunction

   function automatic stdp_tb_pkg::synapse_result_type synapse_step(
         logic [1:0] cmd, logic [31:0] now, logic signed [31:0] sig, logic [5:0] dly);
      stdp_tb_pkg::synapse_result_type r;
      logic [63:0] aw, as_, m, mag;
      logic neg;
      logic signed [31:0] stored;
      logic [31:0] t;
      int unsigned len;
      len = ring_length();
      r = '0;
      case (cmd)
         stdp_pkg::CMD_WRITE: begin
            aw = magnitude(weight_q);
            as_ = magnitude(strength_q);
            stored = 0;
            if (aw + as_ != 0) begin
               m = (aw * as_) / (aw + as_);
               mag = (magnitude(sig) * m) >> 16;
               neg = (sig < 0) ^ (weight_q < 0) ^ (strength_q < 0);
               if (neg) stored = (mag >= 64'h80000000) ? 32'sh80000000 : -$signed(mag[31:0]);
               else stored = (mag > 64'h7fffffff) ? 32'sh7fffffff : mag[31:0];
            end
            ring_q[(now % len) % DEPTH] = stored;
         end
         stdp_pkg::CMD_READ: begin
            t = now - 32'(dly) - 32'd1;
            r.signal_out = ring_q[(t % len) % DEPTH];
         end
         stdp_pkg::CMD_PRE: begin
            pre_t = now;
            pre_ok = 1;
            if (proto_q) r.activity = 1;
            else if (post_ok) pair_strength(now, post_t, pre_win_q, pre_rate_q);
         end
         default: begin
            post_t = now;
            post_ok = 1;
            if (pre_ok) begin
               if (proto_q) begin
                  if (now - pre_t < {16'd0, post_win_q} && maturity_q != 16'hffff)
                     maturity_q++;
               end else begin
                  pair_strength(now, pre_t, post_win_q, post_rate_q);
               end
            end
         end
      endcase
      r.strength_now = strength_q;
      r.maturity_now = maturity_q;
      return r;
   endfunction

   function automatic logic idle_roll();
      return !quiet && $urandom_range(99) < 31;
   endfunction

   task automatic send_item(logic [1:0] cmd, logic [31:0] now,
                            logic signed [31:0] sig, logic [5:0] dly);
      stdp_tb_pkg::synapse_result_type want;
      while (idle_roll()) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1; req.cmd <= cmd; req.tick_time <= now;
      req.signal_in <= sig; req.read_delay <= dly;
      do @(posedge clock); while (!req.ready);
      want = synapse_step(cmd, now, sig, dly);
      expected_results = {expected_results, want};
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] v);
      drain();
      csr.valid <= 1'b1; csr.index <= 4'(idx); csr.data <= v;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
      synapse_config(idx, v);
   endtask

   // response side
   always @(posedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else rsp.ready <= !idle_roll();
   end

   always @(posedge clock) begin
      stdp_tb_pkg::synapse_result_type got, want;
      if (!reset && rsp.valid && rsp.ready) begin
         got = '{rsp.signal_out, rsp.strength_now, rsp.maturity_now, rsp.activity};
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            failures++;
         end else begin
            want = expected_results.pop_front();
            if (got.signal_out !== want.signal_out) begin
               $display("%0t: signal_out exp %h got %h", $time, want.signal_out, got.signal_out);
               failures++;
            end
            if (got.strength_now !== want.strength_now) begin
               $display("%0t: strength_now exp %h got %h", $time, want.strength_now,
                        got.strength_now);
               failures++;
            end
            if (got.maturity_now !== want.maturity_now) begin
               $display("%0t: maturity_now exp %h got %h", $time, want.maturity_now,
                        got.maturity_now);
               failures++;
            end
            if (got.activity !== want.activity) begin
               $display("%0t: activity exp %b got %b", $time, want.activity, got.activity);
               failures++;
            end
         end
      end
   end

   task automatic test_ring_directed();
      send_item(stdp_pkg::CMD_WRITE, 32'd5, 32'sh7fffffff, 6'd0);
      send_item(stdp_pkg::CMD_WRITE, 32'd6, 32'sh80000000, 6'd0);
      send_item(stdp_pkg::CMD_WRITE, 32'hffffffff, 32'sh00010000, 6'd0);
      send_item(stdp_pkg::CMD_READ, 32'd6, 32'sd0, 6'd0);
      send_item(stdp_pkg::CMD_READ, 32'd7, 32'sd0, 6'd0);
      send_item(stdp_pkg::CMD_READ, 32'd0, 32'sd0, 6'd0);
      send_item(stdp_pkg::CMD_READ, 32'd5, 32'sd0, 6'd63);
      write_reg(stdp_pkg::REG_WEIGHT, 32'sh80000000);
      send_item(stdp_pkg::CMD_WRITE, 32'd9, -32'sd12345, 6'd0);
      send_item(stdp_pkg::CMD_READ, 32'd10, 32'sd0, 6'd0);
      write_reg(stdp_pkg::REG_INIT_STRENGTH, 32'd0);
      write_reg(stdp_pkg::REG_WEIGHT, 32'd0);
      send_item(stdp_pkg::CMD_WRITE, 32'd11, 32'sh7fffffff, 6'd0);
      send_item(stdp_pkg::CMD_READ, 32'd12, 32'sd0, 6'd0);
      write_reg(stdp_pkg::REG_HISTORY_LEN, 32'd1);
      send_item(stdp_pkg::CMD_READ, 32'd0, 32'sd0, 6'd0);
      write_reg(stdp_pkg::REG_HISTORY_LEN, 32'd0);
      send_item(stdp_pkg::CMD_READ, 32'd3, 32'sd0, 6'd2);
      write_reg(stdp_pkg::REG_HISTORY_LEN, 32'd127);
      send_item(stdp_pkg::CMD_READ, 32'd12, 32'sd0, 6'd0);
   endtask

   task automatic test_pairing_directed();
      write_reg(stdp_pkg::REG_INIT_STRENGTH, 32'sh7fff0000);
      write_reg(stdp_pkg::REG_POST_RATE, 32'sh7fffffff);
      write_reg(stdp_pkg::REG_PRE_RATE, 32'sh80000000);
      write_reg(stdp_pkg::REG_PRE_WINDOW, 32'hffff);
      write_reg(stdp_pkg::REG_POST_WINDOW, 32'd1);
      send_item(stdp_pkg::CMD_POST, 32'd100, 32'sd0, 6'd0);
      send_item(stdp_pkg::CMD_PRE, 32'd100, 32'sd0, 6'd0);
      send_item(stdp_pkg::CMD_POST, 32'd100, 32'sd0, 6'd0);
      send_item(stdp_pkg::CMD_POST, 32'd101, 32'sd0, 6'd0);
      send_item(stdp_pkg::CMD_PRE, 32'd3, 32'sd0, 6'd0);
      write_reg(stdp_pkg::REG_PROTO_MODE, 32'd1);
      send_item(stdp_pkg::CMD_PRE, 32'd200, 32'sd0, 6'd0);
      send_item(stdp_pkg::CMD_POST, 32'd200, 32'sd0, 6'd0);
      send_item(stdp_pkg::CMD_POST, 32'd201, 32'sd0, 6'd0);
      write_reg(stdp_pkg::REG_PROTO_MODE, 32'd0);
   endtask

   task automatic random_config();
      write_reg(stdp_pkg::REG_PROTO_MODE, $urandom_range(1));
      write_reg(stdp_pkg::REG_WEIGHT,
                ($urandom_range(3) == 0) ? $urandom : $urandom_range(200000));
      write_reg(stdp_pkg::REG_INIT_STRENGTH,
                ($urandom_range(3) == 0) ? $urandom : $urandom_range(200000));
      write_reg(stdp_pkg::REG_PRE_WINDOW,
                ($urandom_range(7) == 0) ? 32'hffff : $urandom_range(1, 60));
      write_reg(stdp_pkg::REG_POST_WINDOW,
                ($urandom_range(7) == 0) ? 32'd1 : $urandom_range(1, 60));
      write_reg(stdp_pkg::REG_PRE_RATE,
                ($urandom_range(3) == 0) ? $urandom : $urandom_range(70000));
      write_reg(stdp_pkg::REG_POST_RATE,
                ($urandom_range(3) == 0) ? $urandom : 32'(-$urandom_range(70000)));
      write_reg(stdp_pkg::REG_HISTORY_LEN, $urandom_range(127));
   endtask

   task automatic test_random_traffic();
      logic [31:0] now;
      logic [1:0] cmd;
      logic signed [31:0] sig;
      now = $urandom;
      for (int n = 0; n < 480; n++) begin
         if (n % 80 == 0) random_config();
         quiet = (n >= 200 && n < 260);
         if (n == 300) drain();
         now = ($urandom_range(9) == 0) ? $urandom : now + $urandom_range(8);
         cmd = 2'($urandom_range(3));
         sig = ($urandom_range(3) == 0) ? $urandom : $signed($urandom_range(262144)) - 131072;
         send_item(cmd, now, sig, 6'($urandom_range(63)));
      end
      quiet = 0;
   endtask

   initial begin
      req.valid = 1'b0; req.cmd = stdp_pkg::CMD_WRITE; req.tick_time = '0;
      req.signal_in = '0; req.read_delay = '0;
      csr.valid = 1'b0; csr.index = '0; csr.data = '0;
      synapse_reset();
      foreach (exp_lut[i]) exp_lut[i] = taylor_exp(i);
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_ring_directed();
      test_pairing_directed();
      test_random_traffic();
      drain();
      if (failures == 0) $display("tb: PASS");
      else $display("tb: FAIL");
      $finish;
   end

   initial begin
      #20ms;
      $display("tb: FAIL");
      $finish;
   end
endmodule
